/* rtl/core/decimal_text_to_signed_integer_unit_macros.svh */
// assertion macros shared by the decimal text to integer unit
`ifndef DECIMAL_TEXT_TO_SIGNED_INTEGER_UNIT_MACROS_SVH
`define DECIMAL_TEXT_TO_SIGNED_INTEGER_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define DTSI_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define DTSI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/dtsi_pkg.sv */
// shared types and constants for the decimal text to integer unit
package dtsi_pkg;

    // integer width of the parsed value
    localparam int INT_BITS_DEF = 64;
    localparam int VALUE_W      = 64;
    localparam int POS_W        = 16;

    // character codes
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // saturation point of the character position
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_EXTRA = 3'd1,
        ST_MORE  = 3'd2,
        ST_INVAL = 3'd3,
        ST_RANGE = 3'd4
    } status_t;

    // parse phase, one-hot
    typedef enum logic [3:0] {
        PH_START  = 4'b0001,
        PH_SIGN   = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    // control state of the parser
    typedef struct packed {
        phase_t           phase;
        logic             negative;
        logic             at_limit;
        logic [POS_W-1:0] count;
    } ctl_t;

    // one result item
    typedef struct packed {
        status_t            status;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   stop_position;
    } result_t;

    localparam ctl_t CTL_RESET = '{
        phase:    PH_START,
        negative: 1'b0,
        at_limit: 1'b0,
        count:    '0
    };

endpackage

/* rtl/core/dtsi_step.sv */
// next-state and result logic for one character or end item
module dtsi_step #(
    parameter int INT_BITS = dtsi_pkg::INT_BITS_DEF
) (
    input  dtsi_pkg::ctl_t    ctl,
    input  logic [INT_BITS-1:0] acc,
    input  logic [7:0]        ch,
    input  logic              is_end,
    output dtsi_pkg::ctl_t    ctl_next,
    output logic [INT_BITS-1:0] acc_next,
    output logic              emit,
    output dtsi_pkg::result_t result
);

    localparam int EXT_W = INT_BITS + 4;
    localparam logic [INT_BITS-1:0] MAX_POS = {1'b0, {(INT_BITS-1){1'b1}}};
    localparam logic [INT_BITS-1:0] BOUND   = MAX_POS / 10;

    logic [EXT_W-1:0]                acc_ext;
    logic [EXT_W-1:0]                prod;
    logic [EXT_W-1:0]                limit;
    logic                            is_digit;
    logic                            overflow;
    logic [dtsi_pkg::POS_W-1:0]      count_inc;
    logic [dtsi_pkg::VALUE_W-1:0]    mag;
    logic [dtsi_pkg::VALUE_W-1:0]    signed_val;

    // ten times the accumulator plus the digit, shift and add
    assign acc_ext  = EXT_W'(acc);
    assign prod     = (acc_ext << 3) + (acc_ext << 1) + EXT_W'(ch[3:0]);
    assign limit    = EXT_W'(MAX_POS) + EXT_W'(ctl.negative);
    assign is_digit = (ch >= dtsi_pkg::CHAR_ZERO) && (ch <= dtsi_pkg::CHAR_NINE);
    assign overflow = ctl.at_limit || (prod > limit);

    // saturating position counter
    assign count_inc = (ctl.count != dtsi_pkg::POS_MAX) ? ctl.count + 1'b1 : ctl.count;

    // signed value, sign extended to the output width
    assign mag        = dtsi_pkg::VALUE_W'(acc);
    assign signed_val = ctl.negative ? ('0 - mag) : mag;

    // parse decision
    always_comb
    begin
        ctl_next             = ctl;
        acc_next             = acc;
        emit                 = 1'b0;
        result.status        = dtsi_pkg::ST_OK;
        result.value         = '0;
        result.stop_position = ctl.count;

        if (is_end)
        begin
            ctl_next = dtsi_pkg::CTL_RESET;
            acc_next = '0;
            unique case (ctl.phase)
                dtsi_pkg::PH_START:
                begin
                    emit                 = 1'b1;
                    result.status        = dtsi_pkg::ST_INVAL;
                    result.stop_position = '0;
                end
                dtsi_pkg::PH_SIGN:
                begin
                    emit          = 1'b1;
                    result.status = dtsi_pkg::ST_MORE;
                end
                dtsi_pkg::PH_DIGITS:
                begin
                    emit          = 1'b1;
                    result.status = dtsi_pkg::ST_OK;
                    result.value  = signed_val;
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
        else if (ctl.phase != dtsi_pkg::PH_DONE)
        begin
            ctl_next.count = count_inc;
            if ((ctl.phase == dtsi_pkg::PH_START) &&
                ((ch == dtsi_pkg::CHAR_MINUS) || (ch == dtsi_pkg::CHAR_PLUS)))
            begin
                ctl_next.negative = (ch == dtsi_pkg::CHAR_MINUS);
                ctl_next.phase    = dtsi_pkg::PH_SIGN;
            end
            else if (is_digit)
            begin
                if (overflow)
                begin
                    emit           = 1'b1;
                    result.status  = dtsi_pkg::ST_RANGE;
                    ctl_next.phase = dtsi_pkg::PH_DONE;
                end
                else
                begin
                    // last legal digit position of a negative value
                    if (ctl.negative && (acc == BOUND))
                    begin
                        ctl_next.at_limit = 1'b1;
                    end
                    acc_next       = prod[INT_BITS-1:0];
                    ctl_next.phase = dtsi_pkg::PH_DIGITS;
                end
            end
            else
            begin
                emit           = 1'b1;
                result.status  = dtsi_pkg::ST_EXTRA;
                result.value   = signed_val;
                ctl_next.phase = dtsi_pkg::PH_DONE;
            end
        end
    end

endmodule

/* rtl/core/decimal_text_to_signed_integer_unit.sv */
// decimal_text_to_signed_integer_unit: signed decimal text parser, one character per item
// a result is registered before it appears on m_tvalid; while the output stalls it waits in the skid register
// throughput: one item per cycle while s_tready is high; the parse step is one add of ten times the
//   accumulator plus a digit and one compare against a limit set by the sign
// result register plus skid register; s_tready drops only while the skid register is full
// reset: rst_n low clears the parser to start of string and empties the output
`include "decimal_text_to_signed_integer_unit_macros.svh"

module decimal_text_to_signed_integer_unit #(
    parameter int INT_BITS = dtsi_pkg::INT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // is_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [63:0] value, [79:64] stop_position
    output logic [2:0]  m_tuser    // [2:0] status
);

    localparam logic [INT_BITS:0] LIMIT_NEG = {2'b01, {(INT_BITS-1){1'b0}}};

    dtsi_pkg::ctl_t      ctl_reg;
    dtsi_pkg::ctl_t      ctl_next;
    logic [INT_BITS-1:0] acc_reg;
    logic [INT_BITS-1:0] acc_next;
    logic                step_emit;
    dtsi_pkg::result_t   step_result;

    logic                out_valid_reg;
    dtsi_pkg::result_t   out_data_reg;
    logic                skid_valid_reg;
    dtsi_pkg::result_t   skid_data_reg;

    logic                accept;
    logic                emit;
    logic                out_hold;

    // handshake
    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign emit     = accept && step_emit;
    assign out_hold = out_valid_reg && !m_tready;

    // parse step
    dtsi_step #(
        .INT_BITS (INT_BITS)
    ) u_step (
        .ctl      (ctl_reg),
        .acc      (acc_reg),
        .ch       (s_tdata),
        .is_end   (s_tlast),
        .ctl_next (ctl_next),
        .acc_next (acc_next),
        .emit     (step_emit),
        .result   (step_result)
    );

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= dtsi_pkg::CTL_RESET;
            acc_reg <= '0;
        end
        else if (accept)
        begin
            ctl_reg <= ctl_next;
            acc_reg <= acc_next;
        end
    end

    // output valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (emit)
        begin
            if (out_hold)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_valid_reg && m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (emit)
        begin
            if (out_hold)
            begin
                skid_data_reg <= step_result;
            end
            else
            begin
                out_data_reg <= step_result;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.stop_position, out_data_reg.value};
    assign m_tuser  = out_data_reg.status;

    // checks
    `DTSI_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid full with output empty")
    `DTSI_ASSERT_NEXT(a_end_rearms, accept && s_tlast,
        (ctl_reg.phase == dtsi_pkg::PH_START) && (ctl_reg.count == '0) && (acc_reg == '0),
        "end item did not rearm parser")
    `DTSI_ASSERT_SAME(a_acc_in_range, 1'b1, ({1'b0, acc_reg} <= LIMIT_NEG),
        "accumulator beyond negative limit")

endmodule

/* test/tb.sv */
// testbench for the decimal text to signed integer unit, self-checking against a built-in predictor
`timescale 1ns / 100ps

module tb;

    localparam logic [63:0] MAG_MAX        = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int          TIMEOUT_CYCLES = 1_000_000;

    // one parse result as seen on the output
    typedef struct {
        dtsi_pkg::status_t status;
        logic [63:0]       value;
        logic [15:0]       stop;
    } parse_result_t;

    // tracks the parser state and holds the results still to come
    class decimal_parse_tracker;
        parse_result_t     expected_q[$];
        dtsi_pkg::phase_t  phase;
        bit                negative;
        bit [63:0]         magnitude;
        bit                at_limit;
        bit [15:0]         count;
        int                errors;

        function new();
            errors = 0;
            rearm();
        endfunction

        function void rearm();
            phase     = dtsi_pkg::PH_START;
            negative  = 1'b0;
            magnitude = '0;
            at_limit  = 1'b0;
            count     = '0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void queue_result(dtsi_pkg::status_t s, logic [63:0] v, logic [15:0] p);
            parse_result_t r;
            r.status = s;
            r.value  = v;
            r.stop   = p;
            expected_q.push_back(r);
        endfunction

        // accepted input item: advance the parser and queue any result it causes
        function void note_item(logic [7:0] c, logic last);
            logic [15:0] pos;
            logic [63:0] digit;
            logic [63:0] ceiling;
            logic [63:0] signed_mag;
            pos        = count;
            signed_mag = negative ? (64'd0 - magnitude) : magnitude;
            // end of string closes whatever is open and rearms
            if (last)
            begin
                case (phase)
                    dtsi_pkg::PH_START:  queue_result(dtsi_pkg::ST_INVAL, '0, '0);
                    dtsi_pkg::PH_SIGN:   queue_result(dtsi_pkg::ST_MORE, '0, pos);
                    dtsi_pkg::PH_DIGITS: queue_result(dtsi_pkg::ST_OK, signed_mag, pos);
                    default: ;
                endcase
                rearm();
                return;
            end
            if (phase == dtsi_pkg::PH_DONE)
                return;
            if (count != dtsi_pkg::POS_MAX)
                count++;
            // optional leading sign
            if (phase == dtsi_pkg::PH_START &&
                (c == dtsi_pkg::CHAR_MINUS || c == dtsi_pkg::CHAR_PLUS))
            begin
                negative = (c == dtsi_pkg::CHAR_MINUS);
                phase    = dtsi_pkg::PH_SIGN;
                return;
            end
            // digit with exact overflow check
            if (c >= dtsi_pkg::CHAR_ZERO && c <= dtsi_pkg::CHAR_NINE)
            begin
                digit   = 64'(c - dtsi_pkg::CHAR_ZERO);
                ceiling = MAG_MAX + (negative ? 64'd1 : 64'd0);
                if (at_limit || magnitude > (ceiling - digit) / 64'd10)
                begin
                    queue_result(dtsi_pkg::ST_RANGE, '0, pos);
                    phase = dtsi_pkg::PH_DONE;
                    return;
                end
                if (negative && magnitude == MAG_MAX / 64'd10)
                    at_limit = 1'b1;
                magnitude = magnitude * 64'd10 + digit;
                phase     = dtsi_pkg::PH_DIGITS;
                return;
            end
            // anything else stops the parse
            queue_result(dtsi_pkg::ST_EXTRA, signed_mag, pos);
            phase = dtsi_pkg::PH_DONE;
        endfunction

        // accepted result: compare with the oldest expectation
        function void check_item(dtsi_pkg::status_t s, logic [63:0] v, logic [15:0] p);
            parse_result_t e;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: status %0d value %0d stop %0d", s, $signed(v), p);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (s !== e.status)
            begin
                $error("status: expected %0d, actual %0d", e.status, s);
                errors++;
            end
            if (v !== e.value)
            begin
                $error("value: expected %0d, actual %0d", $signed(e.value), $signed(v));
                errors++;
            end
            if (p !== e.stop)
            begin
                $error("stop_position: expected %0d, actual %0d", e.stop, p);
                errors++;
            end
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [7:0] ch
    logic        s_tlast  = 1'b0; // is_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;         // [63:0] value, [79:64] stop_position
    logic [2:0]  m_tuser;         // [2:0] status

    decimal_parse_tracker tracker = new();

    int         src_idle   = 0;
    int         dst_idle   = 0;
    int         items_sent = 0;
    logic [7:0] text_q[$];

    decimal_text_to_signed_integer_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver stalls
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= dst_idle);
    end

    // watch both handshakes
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            tracker.note_item(s_tdata, s_tlast);
        if (rst_n && m_tvalid && m_tready)
            tracker.check_item(dtsi_pkg::status_t'(m_tuser), m_tdata[63:0], m_tdata[79:64]);
    end

    // one item, with random idle cycles ahead of it
    task automatic send_item(input logic [7:0] c, input logic last);
        while ($urandom_range(0, 99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    function automatic void append_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            text_q.push_back(txt[i]);
    endfunction

    // send the queued characters, then the end item with a random byte
    task automatic send_string();
        foreach (text_q[i])
            send_item(text_q[i], 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
        text_q.delete();
    endtask

    // hold the sender until every result is in
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (tracker.pending() != 0);
    endtask

    function automatic logic [7:0] random_digit();
        return dtsi_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] random_non_digit();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0: c = dtsi_pkg::CHAR_ZERO - 8'd1;
            1: c = dtsi_pkg::CHAR_NINE + 8'd1;
            default:
            begin
                do c = 8'($urandom_range(0, 255));
                while (c >= dtsi_pkg::CHAR_ZERO && c <= dtsi_pkg::CHAR_NINE);
            end
        endcase
        return c;
    endfunction

    // one random string, mostly well-formed numbers, some at the interesting edges
    task automatic random_string();
        int    kind;
        int    len;
        string limits[10];
        limits = '{"9223372036854775807", "9223372036854775808", "9223372036854775806",
                   "-9223372036854775808", "-9223372036854775809", "-9223372036854775807",
                   "+9223372036854775807", "99999999999999999999", "-922337203685477580",
                   "922337203685477580"};
        kind = $urandom_range(0, 99);
        if (kind < 40)
        begin
            // signed digit run
            case ($urandom_range(0, 2))
                1: text_q.push_back(dtsi_pkg::CHAR_PLUS);
                2: text_q.push_back(dtsi_pkg::CHAR_MINUS);
                default: ;
            endcase
            len = $urandom_range(1, 20);
            repeat (len)
                text_q.push_back(random_digit());
        end
        else if (kind < 60)
        begin
            // numbers at the range limits, maybe one digit longer, maybe with a non-digit after
            append_text(limits[$urandom_range(0, 9)]);
            if ($urandom_range(0, 1))
                text_q.push_back(random_digit());
            if ($urandom_range(0, 3) == 0)
                text_q.push_back(random_non_digit());
        end
        else if (kind < 80)
        begin
            // digits, a stray character, then trailing junk
            if ($urandom_range(0, 2) == 0)
                text_q.push_back($urandom_range(0, 1) ? dtsi_pkg::CHAR_MINUS
                                                      : dtsi_pkg::CHAR_PLUS);
            len = $urandom_range(0, 6);
            repeat (len)
                text_q.push_back(random_digit());
            text_q.push_back(random_non_digit());
            len = $urandom_range(0, 4);
            repeat (len)
                text_q.push_back($urandom_range(0, 1) ? random_digit()
                                                      : 8'($urandom_range(0, 255)));
        end
        else if (kind < 95)
        begin
            // raw bytes
            len = $urandom_range(0, 6);
            repeat (len)
                text_q.push_back(8'($urandom_range(0, 255)));
        end
        else if ($urandom_range(0, 1))
        begin
            text_q.push_back($urandom_range(0, 1) ? dtsi_pkg::CHAR_MINUS
                                                  : dtsi_pkg::CHAR_PLUS);
        end
        send_string();
    endtask

    task automatic random_phase(input int upto);
        while (items_sent < upto)
        begin
            if ($urandom_range(0, 99) < 3)
                drain();
            random_string();
        end
        drain();
    endtask

    // reset
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // stimulus
    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        src_idle = 33;
        dst_idle = 62;

        // empty, lone signs, stray after sign, double sign
        send_string();
        append_text("+");
        send_string();
        append_text("-");
        send_string();
        append_text("-x");
        send_string();
        append_text("+-");
        send_string();
        // byte extremes as first character
        text_q.push_back(8'h00);
        send_string();
        text_q.push_back(8'hFF);
        send_string();
        // stop on a letter, later characters ignored
        append_text("12a5");
        send_string();
        append_text("0");
        foreach (text_q[i])
            send_item(text_q[i], 1'b0);
        text_q.delete();
        send_item(8'hFF, 1'b1);
        drain();

        random_phase(190);

        src_idle = 62;
        dst_idle = 33;
        random_phase(360);

        src_idle = 0;
        dst_idle = 0;
        random_phase(items_sent + 170);

        repeat (10) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_CYCLES * 20);
        $display("TB_ERROR");
        $finish;
    end

endmodule
